/* rtl/keyframe_linear_interpolator_unit_defines.svh */
// Assertion macros shared by the keyframe interpolator RTL.
`ifndef KEYFRAME_LINEAR_INTERPOLATOR_UNIT_DEFINES_SVH
`define KEYFRAME_LINEAR_INTERPOLATOR_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define KLI_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("kli assertion failed");

// Next-cycle implication, checked on every clock edge outside reset.
`define KLI_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("kli assertion failed");

`endif

/* rtl/kli_pkg.sv */
// Package with types, codes and widths of the keyframe interpolator.
`default_nettype none
package kli_pkg;

	localparam int MAX_KEYFRAMES_DEF = 16;

	localparam int TIME_W = 17;
	localparam int VAL_W  = 8;
	localparam int NUM_W  = TIME_W + VAL_W;

	localparam logic [1:0] OP_CLEAR  = 2'd0;
	localparam logic [1:0] OP_APPEND = 2'd1;
	localparam logic [1:0] OP_EVAL   = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic [TIME_W-1:0] ktime;
		logic [VAL_W-1:0]  kval;
	} kf_entry_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN_RD,
		S_SCAN_CMP,
		S_MUL_A,
		S_MUL_B,
		S_DIV_START,
		S_DIV_WAIT,
		S_DONE
	} state_t;

endpackage
`default_nettype wire

/* rtl/kli_table.sv */
// Keyframe table memory with one write port and one registered read port.
`default_nettype none
module kli_table #(
	parameter int DEPTH = kli_pkg::MAX_KEYFRAMES_DEF,
	parameter int AW = $clog2(DEPTH)
) (
	input  wire logic                clk,
	input  wire logic                we,
	input  wire logic [AW-1:0]       waddr,
	input  wire kli_pkg::kf_entry_t  wdata,
	input  wire logic [AW-1:0]       raddr,
	output kli_pkg::kf_entry_t       rdata
);

	kli_pkg::kf_entry_t mem [DEPTH];
	kli_pkg::kf_entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

/* rtl/kli_div.sv */
// Restoring divider that yields one quotient bit per cycle.
`default_nettype none
module kli_div (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [kli_pkg::NUM_W-1:0]     num,
	input  wire logic [kli_pkg::TIME_W-1:0]    den,
	output logic                               done,
	output logic [kli_pkg::VAL_W-1:0]          quo
);

	localparam int TW = kli_pkg::TIME_W;
	localparam int QW = kli_pkg::VAL_W;
	localparam int CNT_W = $clog2(QW);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [TW-1:0]    rem_q;
	logic [TW-1:0]    den_q;
	logic [QW-1:0]    low_q;
	logic [QW-1:0]    quo_q;
	logic [TW:0]      trial;
	logic             fits;

	// The quotient is known to fit in QW bits, so the upper part of the
	// numerator is already below the divisor and seeds the remainder.
	assign trial = {rem_q, low_q[QW-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(QW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num[kli_pkg::NUM_W-1:QW];
			low_q <= num[QW-1:0];
			den_q <= den;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= TW'(trial - {1'b0, den_q});
			end else begin
				rem_q <= trial[TW-1:0];
			end
			low_q <= {low_q[QW-2:0], 1'b0};
			quo_q <= {quo_q[QW-2:0], fits};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule
`default_nettype wire

/* rtl/keyframe_linear_interpolator_unit.sv */
// Top level of the keyframe interpolator: sequencer, shared multiplier and output register.
//
//  Channel | Handshake          | Fields
//  --------+--------------------+-------------------------------------------
//  in      | in_valid, in_stall | op, key_time, key_value, query_time
//  out     | out_valid,out_stall| value, status
//
// Clear, append, unused codes and evaluate on an empty table go straight from
// acceptance to DONE. Evaluate otherwise reads one entry per SCAN_RD/SCAN_CMP
// pair per keyframe scanned, then goes to DONE when it clamps, or through
// MUL_A, MUL_B, DIV_START and DIV_WAIT when it interpolates, the divider giving
// one quotient bit per cycle. One item is in work at a time; in_stall is high
// from acceptance until the result is loaded into the output register.
// Reset clears the sequencer, the keyframe count and the output valid flag.
`default_nettype none
`include "keyframe_linear_interpolator_unit_defines.svh"
module keyframe_linear_interpolator_unit #(
	parameter int MAX_KEYFRAMES = kli_pkg::MAX_KEYFRAMES_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic [1:0]                   op,
	input  wire logic [kli_pkg::TIME_W-1:0]   key_time,
	input  wire logic [kli_pkg::VAL_W-1:0]    key_value,
	input  wire logic [kli_pkg::TIME_W-1:0]   query_time,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic [kli_pkg::VAL_W-1:0]         value,
	output logic [1:0]                        status
);

	localparam int AW = $clog2(MAX_KEYFRAMES);
	localparam int CW = $clog2(MAX_KEYFRAMES + 1);
	localparam int TW = kli_pkg::TIME_W;
	localparam int VW = kli_pkg::VAL_W;
	localparam int NW = kli_pkg::NUM_W;

	kli_pkg::state_t state_q, state_d;

	logic [CW-1:0] count_q;
	logic [CW-1:0] idx_q;
	logic [CW-1:0] idx_inc;
	logic [TW-1:0] qt_q;
	logic [TW-1:0] t1_q, t2_q;
	logic [VW-1:0] v1_q, v2_q;
	logic [NW-1:0] acc_q;
	logic [VW-1:0] res_value_q;
	logic [1:0]    res_status_q;
	logic          out_valid_q;
	logic [VW-1:0] value_q;
	logic [1:0]    status_q;

	logic          accept;
	logic          full;
	logic          tbl_we;
	logic          div_start;
	logic          div_done;
	logic [VW-1:0] div_quo;
	logic          out_free;
	logic          found;
	logic          sel_a;
	logic [VW-1:0] mul_a;
	logic [TW-1:0] mul_b;
	logic [NW-1:0] mul_p;

	kli_pkg::kf_entry_t wr_entry;
	kli_pkg::kf_entry_t rd_entry;

	assign accept   = in_valid && !in_stall;
	assign full     = count_q >= CW'(MAX_KEYFRAMES);
	assign idx_inc  = idx_q + CW'(1);
	assign found    = rd_entry.ktime > qt_q;
	assign out_free = !out_valid_q || !out_stall;
	assign wr_entry = '{ktime: key_time, kval: key_value};

	// One multiplier serves both products of the interpolation.
	assign mul_a = sel_a ? v1_q : v2_q;
	assign mul_b = sel_a ? TW'(t2_q - qt_q) : TW'(qt_q - t1_q);
	assign mul_p = NW'(mul_a) * NW'(mul_b);

	kli_table #(
		.DEPTH (MAX_KEYFRAMES)
	) u_table (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (count_q[AW-1:0]),
		.wdata (wr_entry),
		.raddr (idx_q[AW-1:0]),
		.rdata (rd_entry)
	);

	kli_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (acc_q),
		.den    (TW'(t2_q - t1_q)),
		.done   (div_done),
		.quo    (div_quo)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			kli_pkg::S_IDLE: begin
				if (accept) begin
					if (op == kli_pkg::OP_EVAL && count_q != '0) begin
						state_d = kli_pkg::S_SCAN_RD;
					end else begin
						state_d = kli_pkg::S_DONE;
					end
				end
			end
			kli_pkg::S_SCAN_RD: begin
				state_d = kli_pkg::S_SCAN_CMP;
			end
			kli_pkg::S_SCAN_CMP: begin
				if (found) begin
					state_d = (idx_q == '0) ? kli_pkg::S_DONE : kli_pkg::S_MUL_A;
				end else if (idx_inc == count_q) begin
					state_d = kli_pkg::S_DONE;
				end else begin
					state_d = kli_pkg::S_SCAN_RD;
				end
			end
			kli_pkg::S_MUL_A: begin
				state_d = kli_pkg::S_MUL_B;
			end
			kli_pkg::S_MUL_B: begin
				state_d = kli_pkg::S_DIV_START;
			end
			kli_pkg::S_DIV_START: begin
				state_d = kli_pkg::S_DIV_WAIT;
			end
			kli_pkg::S_DIV_WAIT: begin
				if (div_done) begin
					state_d = kli_pkg::S_DONE;
				end
			end
			kli_pkg::S_DONE: begin
				if (out_free) begin
					state_d = kli_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = kli_pkg::S_IDLE;
			end
		endcase
	end

	always_comb begin
		in_stall  = state_q != kli_pkg::S_IDLE;
		tbl_we    = 1'b0;
		div_start = 1'b0;
		sel_a     = 1'b0;
		case (state_q)
			kli_pkg::S_IDLE: begin
				tbl_we = accept && op == kli_pkg::OP_APPEND && !full;
			end
			kli_pkg::S_MUL_A: begin
				sel_a = 1'b1;
			end
			kli_pkg::S_DIV_START: begin
				div_start = 1'b1;
			end
			default: begin
				sel_a = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= kli_pkg::S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept && op == kli_pkg::OP_CLEAR) begin
				count_q <= '0;
			end else if (tbl_we) begin
				count_q <= count_q + CW'(1);
			end
			if (state_q == kli_pkg::S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			kli_pkg::S_IDLE: begin
				idx_q        <= '0;
				qt_q         <= query_time;
				res_value_q  <= '0;
				res_status_q <= kli_pkg::ST_OK;
				if (op == kli_pkg::OP_APPEND && full) begin
					res_status_q <= kli_pkg::ST_FULL;
				end else if (op == kli_pkg::OP_EVAL && count_q == '0) begin
					res_status_q <= kli_pkg::ST_EMPTY;
				end
			end
			kli_pkg::S_SCAN_CMP: begin
				if (found) begin
					t2_q        <= rd_entry.ktime;
					v2_q        <= rd_entry.kval;
					res_value_q <= rd_entry.kval;
				end else begin
					t1_q        <= rd_entry.ktime;
					v1_q        <= rd_entry.kval;
					res_value_q <= rd_entry.kval;
					idx_q       <= idx_inc;
				end
			end
			kli_pkg::S_MUL_A: begin
				acc_q <= mul_p;
			end
			kli_pkg::S_MUL_B: begin
				acc_q <= acc_q + mul_p;
			end
			kli_pkg::S_DIV_WAIT: begin
				if (div_done) begin
					res_value_q <= div_quo;
				end
			end
			kli_pkg::S_DONE: begin
				if (out_free) begin
					value_q  <= res_value_q;
					status_q <= res_status_q;
				end
			end
			default: begin
				idx_q <= idx_q;
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign value     = value_q;
	assign status    = status_q;

	`KLI_ASSERT_NEXT(a_busy_after_accept, accept, in_stall)
	`KLI_ASSERT_NOW(a_count_bounded, 1'b1, count_q <= CW'(MAX_KEYFRAMES))
	`KLI_ASSERT_NOW(a_div_done_in_wait, div_done, state_q == kli_pkg::S_DIV_WAIT)
	`KLI_ASSERT_NOW(a_empty_gives_zero, out_valid && status == kli_pkg::ST_EMPTY, value == '0)

endmodule
`default_nettype wire
